// ===== hw/rtl/assert_macros.svh =====
// Assertion macros shared by the RTL of the scheduler unit.
// Included by files that carry concurrent assertions.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
// Property must hold at every clock edge outside reset.
`define ASSERT_ALWAYS(label, clk, rst_n, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);
// Antecedent implies consequent at the same edge.
`define ASSERT_IMPLIES(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);
`endif

// ===== hw/rtl/srts_pkg.sv =====
// Package of the shortest-remaining-time scheduler unit.
// Holds widths, sizes and the sequencer state codes; depends on nothing.
package srts_pkg;
  localparam int unsigned MaxProcs = 64;
  localparam int unsigned IdxW     = 6;
  localparam int unsigned CntW     = 7;
  localparam int unsigned TimeW    = 16;
  localparam int unsigned TickW    = 23;
  localparam int unsigned TotW     = 29;

  typedef logic [IdxW-1:0]  idx_t;
  typedef logic [CntW-1:0]  cnt_t;
  typedef logic [TimeW-1:0] time_t;
  typedef logic [TickW-1:0] tick_t;
  typedef logic [TotW-1:0]  tot_t;

  localparam logic [2:0] StLoad = 3'd0;
  localparam logic [2:0] StScan = 3'd1;
  localparam logic [2:0] StRun  = 3'd2;
  localparam logic [2:0] StWr   = 3'd3;
  localparam logic [2:0] StOut  = 3'd4;
  localparam logic [2:0] StOutW = 3'd5;
endpackage

// ===== hw/rtl/shortest_remaining_time_scheduler_unit.sv =====
// Shortest-remaining-time scheduler unit: top level.
// Depends on srts_pkg and assert_macros.svh.
//
// Usage: process words come in on the input channel (arrival, burst, last
// flag), one per cycle while loading. Up to 64 processes are kept; further
// words are dropped. A word with last_process set starts a preemptive
// shortest-remaining-time simulation, during which in_stall_o is high.
// Each simulation segment scans the per-process memory one entry a cycle,
// with added steps for the memory read latency and the end check, holds
// the selection in StRun and writes the selected entry back in StWr. A
// segment ends at completion of the running process or at the next arrival.
// Results then leave in index order, one word at a time, each through a
// memory read, a load of the output register and the hand-over; a stall
// of the receiver holds the output word and the sequencer. Totals and
// final_result accompany the last word. After it is taken, the unit clears
// its count and accepts a new set. Reset empties the set.
`include "assert_macros.svh"
module shortest_remaining_time_scheduler_unit
  import srts_pkg::*;
(
  input  logic                    clk_i,
  input  logic                    rst_ni,
  input  logic                    in_valid_i,
  output logic                    in_stall_o,
  input  logic [15:0]             arrival_time_i,
  input  logic [15:0]             burst_time_i,
  input  logic                    last_process_i,
  output logic                    out_valid_o,
  input  logic                    out_stall_i,
  output logic [5:0]              process_index_o,
  output logic [22:0]             completion_time_o,
  output logic [22:0]             turnaround_time_o,
  output logic [22:0]             waiting_time_o,
  output logic [22:0]             response_time_o,
  output logic [28:0]             total_turnaround_o,
  output logic [28:0]             total_waiting_o,
  output logic [28:0]             total_response_o,
  output logic                    final_result_o
);
  // One memory word per process.
  typedef struct packed {
    time_t arr;
    time_t bur;
    time_t rem;
    logic  fin;
    tick_t start;
    tick_t comp;
  } ent_t;

  ent_t mem_q [MaxProcs];
  ent_t rd_q;
  logic we;
  idx_t wa, ra;
  ent_t wd;

  // Synchronous memory, one write and one read port.
  always_ff @(posedge clk_i) begin
    if (we) mem_q[wa] <= wd;
    rd_q <= mem_q[ra];
  end

  logic [2:0] st_q, st_d;
  cnt_t cnt_q;
  cnt_t done_q;
  tick_t tick_q;
  cnt_t ptr_q;
  logic rv_q;
  idx_t rvi_q;
  logic sel_v_q;
  idx_t sel_q;
  time_t sel_rem_q, sel_arr_q;
  logic nx_v_q;
  time_t nx_q;
  ent_t ent_q;
  tot_t tt_q, tw_q, tr_q;

  logic out_v_q;
  logic accept, out_take;
  assign accept   = in_valid_i && !in_stall_o;
  assign out_take = out_v_q && !out_stall_i;
  assign in_stall_o = (st_q != StLoad);
  assign out_valid_o = out_v_q;

  // Combinational view of the entry being scanned.
  logic arrived, better;
  assign arrived = ({7'd0, rd_q.arr} <= tick_q);
  assign better  = !sel_v_q || (rd_q.rem < sel_rem_q) ||
                   ((rd_q.rem == sel_rem_q) && (rd_q.arr < sel_arr_q));

  // Run length for the selected process.
  tick_t gap, runl;
  assign gap  = {7'd0, nx_q} - tick_q;
  assign runl = (nx_v_q && gap < {7'd0, ent_q.rem}) ? gap : {7'd0, ent_q.rem};

  // Result arithmetic on the entry read for output.
  tick_t tat, wt, rt;
  assign tat = rd_q.comp - {7'd0, rd_q.arr};
  assign wt  = tat - {7'd0, rd_q.bur};
  assign rt  = rd_q.start - {7'd0, rd_q.arr};

  // Memory port control and sequencer next state.
  always_comb begin
    we = 1'b0;
    wa = cnt_q[IdxW-1:0];
    wd = ent_q;
    ra = ptr_q[IdxW-1:0];
    st_d = st_q;
    unique case (st_q)
      StLoad: begin
        we = accept && (cnt_q < cnt_t'(MaxProcs));
        wd.arr = arrival_time_i;
        wd.bur = (burst_time_i == '0) ? time_t'(1) : burst_time_i;
        wd.rem = wd.bur;
        wd.fin = 1'b0;
        wd.start = '0;
        wd.comp = '0;
        if (accept && last_process_i) st_d = StScan;
      end
      StScan: if (!rv_q && ptr_q >= cnt_q && ptr_q != '0) st_d = StRun;
      StRun: st_d = StWr;
      StWr: begin
        we = sel_v_q;
        wa = sel_q;
        wd.rem = ent_q.rem - runl[TimeW-1:0];
        wd.fin = (wd.rem == '0);
        wd.comp = tick_q + runl;
        if (ent_q.rem == ent_q.bur) wd.start = tick_q;
        st_d = StScan;
        if (sel_v_q && wd.fin && done_q + 1'b1 == cnt_q) st_d = StOut;
      end
      StOut: st_d = StOutW;
      StOutW: begin
        if (out_take) begin
          if (final_result_o) st_d = StLoad;
          else st_d = StOut;
        end
      end
      default: st_d = StLoad;
    endcase
  end

  // Sequencer registers.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q <= StLoad;
      cnt_q <= '0;
      done_q <= '0;
      tick_q <= '0;
      ptr_q <= '0;
      rv_q <= 1'b0;
      sel_v_q <= 1'b0;
      nx_v_q <= 1'b0;
      out_v_q <= 1'b0;
    end else begin
      st_q <= st_d;
      if (out_take) out_v_q <= 1'b0;
      unique case (st_q)
        StLoad: begin
          if (we) cnt_q <= cnt_q + 1'b1;
          ptr_q <= '0;
          done_q <= '0;
          tick_q <= '0;
          sel_v_q <= 1'b0;
          nx_v_q <= 1'b0;
          rv_q <= 1'b0;
        end
        StScan: begin
          rv_q <= (ptr_q < cnt_q);
          if (ptr_q < cnt_q) ptr_q <= ptr_q + 1'b1;
          if (rv_q && !rd_q.fin) begin
            if (arrived) begin
              if (better) begin
                sel_v_q <= 1'b1;
                sel_q <= rvi_q;
                sel_rem_q <= rd_q.rem;
                sel_arr_q <= rd_q.arr;
                ent_q <= rd_q;
              end
            end else if (!nx_v_q || rd_q.arr < nx_q) begin
              nx_v_q <= 1'b1;
              nx_q <= rd_q.arr;
            end
          end
        end
        StRun: ;
        StWr: begin
          ptr_q <= '0;
          sel_v_q <= 1'b0;
          nx_v_q <= 1'b0;
          rv_q <= 1'b0;
          if (sel_v_q) begin
            tick_q <= tick_q + runl;
            if (wd.fin) done_q <= done_q + 1'b1;
          end else begin
            tick_q <= {7'd0, nx_q};
          end
          if (st_d == StOut) begin
            tt_q <= '0;
            tw_q <= '0;
            tr_q <= '0;
          end
        end
        StOut: ;
        StOutW: begin
          if (!out_v_q && ptr_q != '1) begin
            out_v_q <= 1'b1;
            process_index_o <= ptr_q[IdxW-1:0];
            completion_time_o <= rd_q.comp;
            turnaround_time_o <= tat;
            waiting_time_o <= wt;
            response_time_o <= rt;
            final_result_o <= (ptr_q + 1'b1 == cnt_q);
            total_turnaround_o <= (ptr_q + 1'b1 == cnt_q) ? tt_q + tot_t'(tat) : '0;
            total_waiting_o <= (ptr_q + 1'b1 == cnt_q) ? tw_q + tot_t'(wt) : '0;
            total_response_o <= (ptr_q + 1'b1 == cnt_q) ? tr_q + tot_t'(rt) : '0;
            tt_q <= tt_q + tot_t'(tat);
            tw_q <= tw_q + tot_t'(wt);
            tr_q <= tr_q + tot_t'(rt);
          end
          if (out_take) begin
            if (final_result_o) cnt_q <= '0;
            else ptr_q <= ptr_q + 1'b1;
          end
        end
        default: ;
      endcase
      if (st_q == StScan) rvi_q <= ptr_q[IdxW-1:0];
    end
  end

  `ASSERT_IMPLIES(a_no_out_while_loading, clk_i, rst_ni, st_q == StLoad, !out_v_q,
    "result word visible while loading")
  `ASSERT_ALWAYS(a_count_range, clk_i, rst_ni, cnt_q <= cnt_t'(MaxProcs),
    "process count beyond capacity")
  `ASSERT_IMPLIES(a_done_bound, clk_i, rst_ni, st_q == StScan, done_q < cnt_q,
    "scan with every process finished")
endmodule

// ===== dv/shortest_remaining_time_scheduler_unit_tb.sv =====
// Testbench of the shortest-remaining-time scheduler unit.
// Drives process words, predicts the per-process results and compares them.
// Depends on srts_pkg and the unit's RTL.
module shortest_remaining_time_scheduler_unit_tb;
  import srts_pkg::*;

  typedef struct packed {
    idx_t  index;
    tick_t completion;
    tick_t turnaround;
    tick_t waiting;
    tick_t response;
    tot_t  tot_turnaround;
    tot_t  tot_waiting;
    tot_t  tot_response;
    logic  final_flag;
  } sched_result_t;

  // Scoreboard: keeps the loaded set, runs the schedule on the last word and
  // queues the expected result words.
  class srtf_scoreboard;
    int unsigned arr_q[MaxProcs];
    int unsigned bur_q[MaxProcs];
    int unsigned count;
    sched_result_t pending[$];
    int errors;

    function void note_process(logic [15:0] arr, logic [15:0] bur, logic last);
      int unsigned rem[MaxProcs];
      int unsigned start_t[MaxProcs];
      int unsigned comp_t[MaxProcs];
      bit done_f[MaxProcs];
      int unsigned finished, now, next_arr, run, tat, wt, rt, t1, t2, t3;
      int sel;
      bit have_next;
      sched_result_t r;
      if (count < MaxProcs) begin
        arr_q[count] = 32'(arr);
        bur_q[count] = (bur == 0) ? 1 : 32'(bur);
        count++;
      end
      if (!last) return;
      for (int i = 0; i < count; i++) begin
        rem[i] = bur_q[i];
        done_f[i] = 0;
      end
      finished = 0;
      now = 0;
      while (finished < count) begin
        sel = -1;
        have_next = 0;
        next_arr = 0;
        for (int i = 0; i < count; i++) begin
          if (done_f[i]) continue;
          if (arr_q[i] <= now) begin
            if (sel < 0 || rem[i] < rem[sel] ||
                (rem[i] == rem[sel] && arr_q[i] < arr_q[sel]))
              sel = i;
          end else if (!have_next || arr_q[i] < next_arr) begin
            next_arr = arr_q[i];
            have_next = 1;
          end
        end
        if (sel < 0) begin
          now = next_arr;
          continue;
        end
        if (rem[sel] == bur_q[sel]) start_t[sel] = now;
        run = rem[sel];
        if (have_next && next_arr - now < run) run = next_arr - now;
        rem[sel] -= run;
        now += run;
        if (rem[sel] == 0) begin
          done_f[sel] = 1;
          comp_t[sel] = now;
          finished++;
        end
      end
      t1 = 0; t2 = 0; t3 = 0;
      for (int i = 0; i < count; i++) begin
        tat = comp_t[i] - arr_q[i];
        wt = tat - bur_q[i];
        rt = start_t[i] - arr_q[i];
        t1 += tat; t2 += wt; t3 += rt;
        r.index = idx_t'(i);
        r.completion = tick_t'(comp_t[i]);
        r.turnaround = tick_t'(tat);
        r.waiting = tick_t'(wt);
        r.response = tick_t'(rt);
        r.final_flag = (i + 1 == count);
        r.tot_turnaround = r.final_flag ? tot_t'(t1) : '0;
        r.tot_waiting = r.final_flag ? tot_t'(t2) : '0;
        r.tot_response = r.final_flag ? tot_t'(t3) : '0;
        pending.push_back(r);
      end
      count = 0;
    endfunction

    function void check_result(sched_result_t act);
      sched_result_t exp_r;
      if (pending.size() == 0) begin
        $error("unexpected result word for process %0d", act.index);
        errors++;
        return;
      end
      exp_r = pending.pop_front();
      if (act.index != exp_r.index) begin
        $error("process_index exp %0d got %0d", exp_r.index, act.index); errors++;
      end
      if (act.completion != exp_r.completion) begin
        $error("completion_time exp %0d got %0d", exp_r.completion, act.completion);
        errors++;
      end
      if (act.turnaround != exp_r.turnaround) begin
        $error("turnaround_time exp %0d got %0d", exp_r.turnaround, act.turnaround);
        errors++;
      end
      if (act.waiting != exp_r.waiting) begin
        $error("waiting_time exp %0d got %0d", exp_r.waiting, act.waiting); errors++;
      end
      if (act.response != exp_r.response) begin
        $error("response_time exp %0d got %0d", exp_r.response, act.response); errors++;
      end
      if (act.tot_turnaround != exp_r.tot_turnaround) begin
        $error("total_turnaround exp %0d got %0d", exp_r.tot_turnaround,
               act.tot_turnaround);
        errors++;
      end
      if (act.tot_waiting != exp_r.tot_waiting) begin
        $error("total_waiting exp %0d got %0d", exp_r.tot_waiting, act.tot_waiting);
        errors++;
      end
      if (act.tot_response != exp_r.tot_response) begin
        $error("total_response exp %0d got %0d", exp_r.tot_response, act.tot_response);
        errors++;
      end
      if (act.final_flag != exp_r.final_flag) begin
        $error("final_result exp %0d got %0d", exp_r.final_flag, act.final_flag);
        errors++;
      end
    endfunction
  endclass

  logic        clk_i;
  logic        rst_ni;
  logic        in_valid_i;
  logic        in_stall_o;
  logic [15:0] arrival_time_i;
  logic [15:0] burst_time_i;
  logic        last_process_i;
  logic        out_valid_o;
  logic        out_stall_i;
  logic [5:0]  process_index_o;
  logic [22:0] completion_time_o, turnaround_time_o, waiting_time_o, response_time_o;
  logic [28:0] total_turnaround_o, total_waiting_o, total_response_o;
  logic        final_result_o;

  srtf_scoreboard sb;
  int unsigned send_idle_pct;
  int unsigned recv_idle_pct;
  int unsigned quiet_cycles;
  int unsigned words_sent;

  localparam int unsigned QuietLimit = 200000;

  shortest_remaining_time_scheduler_unit dut (.*);

  // Clock generation.
  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Receiver stall, redrawn every cycle.
  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  // Check every accepted result word.
  always @(posedge clk_i) begin
    if (rst_ni && out_valid_o && !out_stall_i) begin
      sb.check_result({process_index_o, completion_time_o, turnaround_time_o,
                       waiting_time_o, response_time_o, total_turnaround_o,
                       total_waiting_o, total_response_o, final_result_o});
    end
  end

  // Watchdog on cycles with no word moving on either side.
  always @(posedge clk_i) begin
    if ((in_valid_i && !in_stall_o) || (out_valid_o && !out_stall_i))
      quiet_cycles <= 0;
    else
      quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles > QuietLimit) begin
      $display("[shortest_remaining_time_scheduler_unit] ERROR");
      $finish;
    end
  end

  // Offer one process word, wait for its acceptance, then maybe idle.
  task automatic send_process(logic [15:0] arr, logic [15:0] bur, logic last);
    in_valid_i <= 1'b1;
    arrival_time_i <= arr;
    burst_time_i <= bur;
    last_process_i <= last;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_process(arr, bur, last);
    words_sent++;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk_i);
    end
  endtask

  // A set of random processes; mostly short ranges so that arrivals overlap.
  task automatic send_set(int unsigned n);
    logic [15:0] a, b;
    int unsigned mode;
    for (int i = 0; i < n; i++) begin
      mode = $urandom_range(9);
      if (mode == 0) begin
        a = 16'($urandom); b = 16'($urandom);
      end else begin
        a = 16'($urandom_range(40)); b = 16'($urandom_range(12));
      end
      send_process(a, b, i == n - 1);
    end
  endtask

  task automatic drain;
    in_valid_i <= 1'b0;
    while (sb.pending.size() != 0) @(posedge clk_i);
    repeat (20) @(posedge clk_i);
  endtask

  initial begin
    sb = new();
    send_idle_pct = 7;
    recv_idle_pct = 58;
    quiet_cycles = 0;
    words_sent = 0;
    rst_ni = 1'b0;
    in_valid_i = 1'b0;
    arrival_time_i = '0;
    burst_time_i = '0;
    last_process_i = 1'b0;
    out_stall_i = 1'b0;
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // Directed: single process at the field extremes, zero burst, ties.
    send_process(16'hFFFF, 16'hFFFF, 1'b1);
    send_process(16'd0, 16'd0, 1'b1);
    send_process(16'd5, 16'd3, 1'b0);
    send_process(16'd0, 16'd3, 1'b0);
    send_process(16'd5, 16'd3, 1'b0);
    send_process(16'd2, 16'd10, 1'b1);
    // Preemption by a shorter arrival, then an idle gap before a late one.
    send_process(16'd0, 16'd20, 1'b0);
    send_process(16'd3, 16'd2, 1'b0);
    send_process(16'd1000, 16'd1, 1'b1);
    drain();
    // Table full: 66 words, the last two dropped, the final one still starts.
    for (int i = 0; i < 66; i++)
      send_process(16'($urandom_range(30)), 16'($urandom_range(6, 1)), i == 65);
    drain();

    // Random sets in three idling phases.
    for (int ph = 0; ph < 3; ph++) begin
      send_idle_pct = (ph == 0) ? 7 : (ph == 1) ? 58 : 0;
      recv_idle_pct = (ph == 0) ? 58 : (ph == 1) ? 7 : 0;
      for (int s = 0; s < 10; s++) begin
        send_set($urandom_range(24, 1));
        if (s == 4) drain();
      end
    end
    drain();
    if (sb.errors == 0)
      $display("[shortest_remaining_time_scheduler_unit] OK");
    else
      $display("[shortest_remaining_time_scheduler_unit] ERROR");
    $finish;
  end
endmodule

// ===== files.f =====
+incdir+hw/rtl
hw/rtl/srts_pkg.sv
hw/rtl/shortest_remaining_time_scheduler_unit.sv
dv/shortest_remaining_time_scheduler_unit_tb.sv
